@@ design/mgbe_pkg.sv @@
`default_nettype none
package mgbe_pkg;

   // default sizes
   localparam int DEF_MAX_LEVELS     = 8;
   localparam int DEF_MAX_FUNCTIONS  = 8;
   localparam int DEF_EXP_TABLE_BITS = 10;

   // fixed field widths
   localparam int FUNC_W     = 3;
   localparam int CIDX_W     = 9;
   localparam int COEFF_W    = 32;
   localparam int POS_W      = 16;
   localparam int VALUE_W    = 32;
   localparam int KROM_W     = 17;
   localparam int KER_W      = 18;
   localparam int BASE_W     = 15;
   localparam int RESULT_LIMIT = 8;

   // beat layout
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_LEVELS      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_FUNCTIONS   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SUBTRACT_ORIGIN = 2'd2;

   // operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_IDX,
      ST_ROM,
      ST_KER,
      ST_MUL,
      ST_ACC,
      ST_FIN
   } state_type;

   // exp(-u) table entry k, u = k / 2^(tb-4), Q1.16, worked out at elaboration
   function automatic logic [KROM_W-1:0] exp_entry(input int unsigned k,
                                                   input int unsigned tb);
      logic [63:0]        s;
      logic [63:0]        term;
      logic [63:0]        ue;
      logic signed [63:0] e;
      s    = 64'(k) << (29 - tb);
      term = 64'd1 << 30;
      e    = 64'sd1 <<< 30;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * s) >> 30) / 64'(n);
         if (n[0]) begin
            e = e - $signed(term);
         end else begin
            e = e + $signed(term);
         end
      end
      ue = (e > 0) ? $unsigned(e) : 64'd0;
      for (int q = 0; q < 5; q++) begin
         ue = (ue * ue + (64'd1 << 29)) >> 30;
      end
      return KROM_W'((ue + (64'd1 << 13)) >> 14);
   endfunction

endpackage
`default_nettype wire

@@ design/multilevel_gaussian_basis_eval_core.sv @@
`default_nettype none
// Multilevel Gaussian basis evaluator. Load beats (req_tuser = 0) write one
// Q16.16 coefficient into the coefficient RAM; loads beyond the table are
// dropped. Evaluate beats (req_tuser = 1) take a Q2.14 position and return
// one beat per function in use, in function order, tlast on the final one,
// tuser set when the Q16.16 sum was clipped. The evaluation runs on one
// shared multiplier under a small sequencer: per coefficient it steps through
// square, shift, exp rom read, kernel, product and accumulate; with
// subtract_origin set the origin kernel is squared, shifted, looked up and
// subtracted too before the product. After each function's last coefficient
// a final step rounds the sum and hands over the result, waiting while the
// result register still holds an unaccepted beat. With L levels each function
// uses 2^L - 1 + L coefficients, and req_tready is low throughout an
// evaluate. Coefficients are undefined until loaded. The result register lets
// the next beat be accepted while the last result still waits.
module multilevel_gaussian_basis_eval_core #(
   parameter int MAX_LEVELS     = mgbe_pkg::DEF_MAX_LEVELS,
   parameter int MAX_FUNCTIONS  = mgbe_pkg::DEF_MAX_FUNCTIONS,
   parameter int EXP_TABLE_BITS = mgbe_pkg::DEF_EXP_TABLE_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [mgbe_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [mgbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // function_index[2:0], coeff_index[11:3], coeff_value[43:12], position[59:44]
   input  wire logic [mgbe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op[0]
   input  wire logic                                req_tuser,
   // result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // result_function[2:0], value[34:3]
   output logic [mgbe_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // saturated[0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int PER_FUNC  = (1 << MAX_LEVELS) - 1 + MAX_LEVELS;
   localparam int DEPTH     = PER_FUNC * MAX_FUNCTIONS;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW        = $clog2(PER_FUNC + 1);
   localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int ROM_SIZE  = 1 << EXP_TABLE_BITS;
   localparam int SHR0      = 33 - EXP_TABLE_BITS;
   localparam int FLIM      = (MAX_FUNCTIONS < mgbe_pkg::RESULT_LIMIT) ?
                              MAX_FUNCTIONS : mgbe_pkg::RESULT_LIMIT;
   localparam int MA_W      = mgbe_pkg::COEFF_W + 1;
   localparam int PROD_W    = MA_W + mgbe_pkg::KER_W;
   localparam int ACC_W     = PROD_W + NW;
   localparam int RW        = ACC_W - 16;
   localparam logic [mgbe_pkg::BASE_W-1:0] BASE_END = 15'h4000;

   // request fields
   logic                               op;
   logic [mgbe_pkg::FUNC_W-1:0]        fn_idx;
   logic [mgbe_pkg::CIDX_W-1:0]        c_idx;
   logic [mgbe_pkg::COEFF_W-1:0]       c_val;
   logic [mgbe_pkg::POS_W-1:0]         pos;
   logic                               req_fire;

   assign op      = req_tuser;
   assign fn_idx  = req_tdata[2:0];
   assign c_idx   = req_tdata[11:3];
   assign c_val   = req_tdata[43:12];
   assign pos     = req_tdata[59:44];
   assign req_fire = req_tvalid && req_tready;

   // configuration registers
   logic [3:0] num_levels_ff;
   logic [3:0] num_functions_ff;
   logic       subtract_origin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff      <= 4'd4;
         num_functions_ff   <= 4'd1;
         subtract_origin_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            mgbe_pkg::CSR_NUM_LEVELS:      num_levels_ff      <= csr_wdata;
            mgbe_pkg::CSR_NUM_FUNCTIONS:   num_functions_ff   <= csr_wdata;
            mgbe_pkg::CSR_SUBTRACT_ORIGIN: subtract_origin_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // exp(-u) rom, constants built at elaboration
   logic [mgbe_pkg::KROM_W-1:0] exp_rom [ROM_SIZE];

   for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
      localparam logic [mgbe_pkg::KROM_W-1:0] ENTRY =
         mgbe_pkg::exp_entry(k, EXP_TABLE_BITS);
      assign exp_rom[k] = ENTRY;
   end

   // coefficient ram
   logic [mgbe_pkg::COEFF_W-1:0] coeff_store_ff [DEPTH];
   logic [mgbe_pkg::COEFF_W-1:0] coeff_q_ff;
   logic [AW-1:0]                wr_addr;
   logic                         wr_en;
   logic [AW-1:0]                rd_addr;

   // sequencer state
   mgbe_pkg::state_type state_ff, state_in;
   logic [mgbe_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [LVL_W-1:0]            lvl_ff, lvl_in;
   logic [LVL_W-1:0]            lvl_last_ff, lvl_last_in;
   logic [mgbe_pkg::BASE_W-1:0] base_ff, base_in;
   logic [NW-1:0]               n_ff, n_in;
   logic [AW-1:0]               func_base_ff, func_base_in;
   logic [mgbe_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [mgbe_pkg::FUNC_W-1:0] func_last_ff, func_last_in;
   logic                        pass_ff, pass_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [EXP_TABLE_BITS-1:0]   idx_ff, idx_in;
   logic                        kval_ff, kval_in;
   logic [mgbe_pkg::KROM_W-1:0] rom_q_ff;
   logic signed [mgbe_pkg::KER_W-1:0] ker_ff, ker_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mgbe_pkg::FUNC_W-1:0] rsp_func_ff, rsp_func_in;
   logic [mgbe_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_sat_ff, rsp_sat_in;
   logic                        rsp_last_ff, rsp_last_in;

   assign wr_en   = req_fire && (op == mgbe_pkg::OP_LOAD) &&
                    (int'(fn_idx) < MAX_FUNCTIONS) && (int'(c_idx) < PER_FUNC);
   assign wr_addr = AW'(AW'(fn_idx) * AW'(PER_FUNC) + AW'(c_idx));
   assign rd_addr = func_base_ff + AW'(n_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coeff_store_ff[wr_addr] <= c_val;
      end
      coeff_q_ff <= coeff_store_ff[rd_addr];
      rom_q_ff   <= exp_rom[idx_ff];
   end

   // shared multiplier: squares the distance, then scales the coefficient
   logic signed [MA_W-1:0]           mul_a;
   logic signed [mgbe_pkg::KER_W-1:0] mul_b;
   logic signed [PROD_W-1:0]         mul_p;
   logic signed [16:0]               delta;
   logic [15:0]                      dist_abs;
   logic [5:0]                       shr;
   logic [31:0]                      sq_shift;
   logic [mgbe_pkg::KROM_W-1:0]      kern;
   logic [mgbe_pkg::BASE_W-1:0]      step_w;
   logic                             out_free;
   logic                             lvl_done;
   logic [3:0]                       nl_eff;
   logic [3:0]                       nf_eff;
   logic signed [ACC_W-1:0]          rnd;
   logic [RW-1:0]                    rval;
   logic                             sat_hi;
   logic                             sat_lo;

   // second pass measures from the origin instead of the position
   assign delta    = (pass_ff ? 17'sd0 : 17'($signed(pos_ff))) -
                     $signed({2'b00, base_ff});
   assign dist_abs = delta[16] ? 16'(-delta) : delta[15:0];
   assign mul_p    = mul_a * mul_b;
   // u index is d^2 scaled by 4^l, dropped to table steps
   assign shr      = 6'(SHR0) - 6'({lvl_ff, 1'b0});
   assign sq_shift = prod_ff[31:0] >> shr;
   assign kern     = kval_ff ? rom_q_ff : '0;
   assign step_w   = BASE_END >> lvl_ff;
   assign lvl_done = (base_ff == BASE_END);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // round half up, then clip to 32 bits
   assign rnd    = acc_ff + ACC_W'(32768);
   assign rval   = rnd[ACC_W-1:16];
   assign sat_hi = !rval[RW-1] && (|rval[RW-1:31]);
   assign sat_lo = rval[RW-1] && !(&rval[RW-1:31]);

   // clamp register settings at evaluate start
   always_comb begin
      if (num_levels_ff == 4'd0) begin
         nl_eff = 4'd1;
      end else if (int'(num_levels_ff) > MAX_LEVELS) begin
         nl_eff = 4'(MAX_LEVELS);
      end else begin
         nl_eff = num_levels_ff;
      end
      if (num_functions_ff == 4'd0) begin
         nf_eff = 4'd1;
      end else if (int'(num_functions_ff) > FLIM) begin
         nf_eff = 4'(FLIM);
      end else begin
         nf_eff = num_functions_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mgbe_pkg::ST_IDLE: begin
            if (req_tvalid && (op == mgbe_pkg::OP_EVAL)) begin
               state_in = mgbe_pkg::ST_SQ;
            end
         end
         mgbe_pkg::ST_SQ:  state_in = mgbe_pkg::ST_IDX;
         mgbe_pkg::ST_IDX: state_in = mgbe_pkg::ST_ROM;
         mgbe_pkg::ST_ROM: state_in = mgbe_pkg::ST_KER;
         mgbe_pkg::ST_KER: begin
            if (!pass_ff && subtract_origin_ff) begin
               state_in = mgbe_pkg::ST_SQ;
            end else begin
               state_in = mgbe_pkg::ST_MUL;
            end
         end
         mgbe_pkg::ST_MUL: state_in = mgbe_pkg::ST_ACC;
         mgbe_pkg::ST_ACC: begin
            if (lvl_done && (lvl_ff == lvl_last_ff)) begin
               state_in = mgbe_pkg::ST_FIN;
            end else begin
               state_in = mgbe_pkg::ST_SQ;
            end
         end
         mgbe_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = (func_ff == func_last_ff) ? mgbe_pkg::ST_IDLE
                                                    : mgbe_pkg::ST_SQ;
            end
         end
         default: state_in = mgbe_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pos_in       = pos_ff;
      lvl_in       = lvl_ff;
      lvl_last_in  = lvl_last_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      func_base_in = func_base_ff;
      func_in      = func_ff;
      func_last_in = func_last_ff;
      pass_in      = pass_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      kval_in      = kval_ff;
      ker_in       = ker_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_func_in  = rsp_func_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         mgbe_pkg::ST_IDLE: begin
            if (req_tvalid && (op == mgbe_pkg::OP_EVAL)) begin
               pos_in       = pos;
               lvl_in       = '0;
               lvl_last_in  = LVL_W'(nl_eff - 4'd1);
               base_in      = '0;
               n_in         = '0;
               func_base_in = '0;
               func_in      = '0;
               func_last_in = mgbe_pkg::FUNC_W'(nf_eff - 4'd1);
               pass_in      = 1'b0;
               acc_in       = '0;
            end
         end
         mgbe_pkg::ST_SQ: begin
            mul_a   = $signed(MA_W'(dist_abs));
            mul_b   = $signed(mgbe_pkg::KER_W'(dist_abs));
            prod_in = mul_p;
         end
         mgbe_pkg::ST_IDX: begin
            idx_in  = sq_shift[EXP_TABLE_BITS-1:0];
            kval_in = ((sq_shift >> EXP_TABLE_BITS) == 32'd0);
         end
         mgbe_pkg::ST_ROM: ;
         mgbe_pkg::ST_KER: begin
            if (pass_ff) begin
               ker_in  = ker_ff - $signed({1'b0, kern});
               pass_in = 1'b0;
            end else begin
               ker_in  = $signed({1'b0, kern});
               pass_in = subtract_origin_ff;
            end
         end
         mgbe_pkg::ST_MUL: begin
            mul_a   = MA_W'($signed(coeff_q_ff));
            mul_b   = ker_ff;
            prod_in = mul_p;
         end
         mgbe_pkg::ST_ACC: begin
            acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
            n_in   = n_ff + NW'(1);
            if (lvl_done) begin
               base_in = '0;
               if (lvl_ff != lvl_last_ff) begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end else begin
               base_in = base_ff + step_w;
            end
         end
         mgbe_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_func_in  = func_ff;
               rsp_sat_in   = sat_hi || sat_lo;
               rsp_last_in  = (func_ff == func_last_ff);
               if (sat_hi) begin
                  rsp_value_in = 32'h7fff_ffff;
               end else if (sat_lo) begin
                  rsp_value_in = 32'h8000_0000;
               end else begin
                  rsp_value_in = rval[31:0];
               end
               acc_in       = '0;
               n_in         = '0;
               lvl_in       = '0;
               base_in      = '0;
               func_in      = func_ff + mgbe_pkg::FUNC_W'(1);
               func_base_in = func_base_ff + AW'(PER_FUNC);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mgbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      lvl_ff       <= lvl_in;
      lvl_last_ff  <= lvl_last_in;
      base_ff      <= base_in;
      n_ff         <= n_in;
      func_base_ff <= func_base_in;
      func_ff      <= func_in;
      func_last_ff <= func_last_in;
      prod_ff      <= prod_in;
      idx_ff       <= idx_in;
      kval_ff      <= kval_in;
      ker_ff       <= ker_in;
      acc_ff       <= acc_in;
      rsp_func_ff  <= rsp_func_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == mgbe_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_value_ff, rsp_func_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // origin pass only runs with subtract_origin set
   a_pass_mode: assert property (@(posedge clock) disable iff (reset)
      pass_ff |-> subtract_origin_ff)
      else $error("origin pass without subtract_origin");

   // plain kernels are never negative
   a_ker_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mgbe_pkg::ST_MUL) && !subtract_origin_ff |-> !ker_ff[mgbe_pkg::KER_W-1])
      else $error("negative kernel without subtract_origin");

   // kernel centers stay inside one unit
   a_base_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mgbe_pkg::ST_IDLE) |-> (base_ff <= BASE_END))
      else $error("kernel center beyond range");

   // an evaluate beat starts the walk
   a_eval_start: assert property (@(posedge clock) disable iff (reset)
      req_fire && (op == mgbe_pkg::OP_EVAL) |=> (state_ff == mgbe_pkg::ST_SQ))
      else $error("evaluate beat did not start sequencer");
`endif

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

   localparam int LEVELS_MAX  = mgbe_pkg::DEF_MAX_LEVELS;
   localparam int FUNCS_MAX   = mgbe_pkg::DEF_MAX_FUNCTIONS;
   localparam int TABLE_BITS  = mgbe_pkg::DEF_EXP_TABLE_BITS;
   localparam int PER_FUNC    = (1 << LEVELS_MAX) - 1 + LEVELS_MAX;
   localparam int ROM_DEPTH   = 1 << TABLE_BITS;
   localparam int IDLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES = 3000;
   localparam int SETTLE      = 40;
   // written part of the table: function 0 up to five levels, all up to two
   localparam int FILL_DEEP   = 36;
   localparam int FILL_WIDE   = 5;

   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [1:0]      addr;
      logic [3:0]      wdata;
      logic            op;
      logic [2:0]      fi;
      logic [8:0]      ci;
      logic [31:0]     cv;
      logic [15:0]     pos;
      bit              zero_sum;   // expected values are plain zeros
   } stim_row_type;

   typedef struct {
      logic [2:0]  func;
      logic [31:0] value;
      logic        sat;
      logic        last;
   } basis_value_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [mgbe_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [mgbe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [mgbe_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [mgbe_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   multilevel_gaussian_basis_eval_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state: coefficient table, raw register values, exp table
   logic signed [31:0] coeff_shadow [FUNCS_MAX][PER_FUNC];
   logic [3:0]         levels_reg = 4'd4;
   logic [3:0]         funcs_reg  = 4'd1;
   logic               origin_reg = 1'b0;
   longint unsigned    gauss_rom [ROM_DEPTH];

   basis_value_type pending_values [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   bit  hold_request = 0;      // asks the receiver for one long hold-off
   bit  quiet_phase = 0;       // no idling on either side
   int  stall_left = 0;
   stim_row_type rows [$];

   initial begin
      forever #6 clock = ~clock;
   end

   // exp(-u) table, u = k / 2^(bits-4): taylor series at u/32, then squared five times
   initial begin
      longint unsigned s, term, ue;
      longint          e;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         s    = longint'(k) << (29 - TABLE_BITS);
         term = 64'd1 << 30;
         e    = 64'sd1 << 30;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * s) >> 30) / longint'(n);
            if (n % 2 == 1) begin
               e = e - longint'(term);
            end else begin
               e = e + longint'(term);
            end
         end
         ue = (e > 0) ? longint'(e) : 64'd0;
         for (int q = 0; q < 5; q++) ue = (ue * ue + (64'd1 << 29)) >> 30;
         gauss_rom[k] = (ue + (64'd1 << 13)) >> 14;
      end
   end

   // one gaussian of the given level at offset d (q.14 units)
   function automatic longint gauss_kernel(int d, int level);
      longint unsigned mag, idx;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      idx = ((mag * mag) << (2 * level + TABLE_BITS - 4)) >> 29;
      return (idx < ROM_DEPTH) ? longint'(gauss_rom[idx]) : 64'sd0;
   endfunction

   function automatic int levels_in_use();
      if (levels_reg == 0) return 1;
      return (levels_reg > LEVELS_MAX) ? LEVELS_MAX : int'(levels_reg);
   endfunction

   function automatic int funcs_in_use();
      int nf;
      nf = (funcs_reg == 0) ? 1 : int'(funcs_reg);
      if (nf > FUNCS_MAX) nf = FUNCS_MAX;
      if (nf > mgbe_pkg::RESULT_LIMIT) nf = mgbe_pkg::RESULT_LIMIT;
      return nf;
   endfunction

   // queue the per-function sums for one position
   function automatic void predict_basis_sums(logic [15:0] pos_bits, bit zero_sum);
      basis_value_type bv;
      int     x, nl, nf, n, base;
      longint acc, kv, r;
      x  = int'($signed(pos_bits));
      nl = levels_in_use();
      nf = funcs_in_use();
      for (int f = 0; f < nf; f++) begin
         acc = 0;
         n   = 0;
         for (int l = 0; l < nl; l++) begin
            for (int i = 0; i <= (1 << l); i++) begin
               base = i * (16384 >> l);
               kv   = gauss_kernel(x - base, l);
               if (origin_reg) kv = kv - gauss_kernel(-base, l);
               acc = acc + longint'(coeff_shadow[f][n]) * kv;
               n++;
            end
         end
         r = (acc + 32768) >>> 16;
         bv.sat = 1'b0;
         if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            bv.sat = 1'b1;
         end
         if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            bv.sat = 1'b1;
         end
         bv.func  = 3'(f);
         bv.value = 32'(r);
         bv.last  = (f == nf - 1);
         // typed-in rows: sum is zero by construction, no clipping
         if (zero_sum) begin
            bv.value = '0;
            bv.sat   = 1'b0;
         end
         pending_values.push_back(bv);
      end
   endfunction

   // accepted request beat: mirror loads, predict evaluates
   function automatic void track_request(logic op, logic [2:0] fi, logic [8:0] ci,
                                         logic [31:0] cv, logic [15:0] pos, bit zero_sum);
      if (op == mgbe_pkg::OP_LOAD) begin
         if (ci < PER_FUNC && fi < FUNCS_MAX) coeff_shadow[fi][ci] = cv;
      end else begin
         predict_basis_sums(pos, zero_sum);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      basis_value_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: func %0d value %h sat %b last %b",
                        rsp_tdata[2:0], rsp_tdata[34:3], rsp_tuser, rsp_tlast);
         end else begin
            want = pending_values.pop_front();
            if (rsp_tdata[2:0] !== want.func || rsp_tdata[34:3] !== want.value ||
                rsp_tuser !== want.sat || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp func %0d value %h sat %b last %b, got %0d %h %b %b",
                           want.func, want.value, want.sat, want.last,
                           rsp_tdata[2:0], rsp_tdata[34:3], rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_request) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_request = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80)
                                                     : $urandom_range(1, 3);
      end
   end

   function automatic int sender_gap();
      if (quiet_phase || $urandom_range(0, 2) != 0) return 0;
      return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
   endfunction

   // offer one beat from the current edge and wait until it is taken
   task automatic send_beat(logic op, logic [2:0] fi, logic [8:0] ci, logic [31:0] cv,
                            logic [15:0] pos, bit zero_sum);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, pos, cv, ci, fi};
      do @(posedge clock); while (!req_tready);
      track_request(op, fi, ci, cv, pos, zero_sum);
   endtask

   // drop valid, then idle for a random gap
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // register write while idle: drain results, let any load retire first
   task automatic write_csr(logic [1:0] addr, logic [3:0] data);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_values.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         mgbe_pkg::CSR_NUM_LEVELS:      levels_reg = data;
         mgbe_pkg::CSR_NUM_FUNCTIONS:   funcs_reg  = data;
         mgbe_pkg::CSR_SUBTRACT_ORIGIN: origin_reg = data[0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] random_coeff();
      case ($urandom_range(0, 3))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 262143)) - 131072);
      endcase
   endfunction

   initial begin
      logic        op;
      logic [2:0]  fi;
      logic [8:0]  ci;
      logic [15:0] pos;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the part of the table that evaluates read: any function count
      // up to two levels, a single function up to five levels
      quiet_phase = 1;
      for (int f = 0; f < FUNCS_MAX; f++)
         for (int c = 0; c < ((f == 0) ? FILL_DEEP : FILL_WIDE); c++)
            send_beat(mgbe_pkg::OP_LOAD, 3'(f), 9'(c), random_coeff(), 16'($urandom()), 0);
      quiet_phase = 0;

      // directed part, reset configuration first (4 levels, 1 function)
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h0000, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 7, 511, 32'hffffffff, 16'h7fff, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h8000, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 7, 262, 32'h7fffffff, 16'hffff, 0});
      // out-of-table loads are dropped
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 0, 263, 32'h12345678, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 0, 511, 32'h80000000, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h4000, 0});
      // single level, saturation both ways
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_NUM_LEVELS, 4'd1, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 0, 0, 32'h7fffffff, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 0, 1, 32'h7fffffff, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h0000, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 0, 0, 32'h80000000, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_LOAD, 0, 1, 32'h80000000, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h2000, 0});
      // origin subtraction at position zero cancels every kernel
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_SUBTRACT_ORIGIN, 4'd1, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_NUM_FUNCTIONS, 4'd8, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h0000, 1});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'hc000, 0});
      // out-of-range register values are clamped
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_NUM_LEVELS, 4'd0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_NUM_FUNCTIONS, 4'd0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'h0100, 0});
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_NUM_FUNCTIONS, 4'd15, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_CSR, mgbe_pkg::CSR_SUBTRACT_ORIGIN, 4'd0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_BEAT, 0, 0, mgbe_pkg::OP_EVAL, 0, 0, 0, 16'hffff, 0});

      foreach (rows[r]) begin
         if (rows[r].kind == ROW_CSR) begin
            write_csr(rows[r].addr, rows[r].wdata);
         end else begin
            send_beat(rows[r].op, rows[r].fi, rows[r].ci, rows[r].cv, rows[r].pos,
                      rows[r].zero_sum);
            idle_sender(sender_gap());
         end
      end

      // random phases: one function at deeper levels, or many at shallow ones
      for (int phase = 0; phase < 4; phase++) begin
         if (phase % 2 == 0) begin
            write_csr(mgbe_pkg::CSR_NUM_LEVELS, 4'($urandom_range(3, 5)));
            write_csr(mgbe_pkg::CSR_NUM_FUNCTIONS, 4'($urandom_range(0, 1)));
         end else begin
            write_csr(mgbe_pkg::CSR_NUM_LEVELS, 4'($urandom_range(0, 2)));
            write_csr(mgbe_pkg::CSR_NUM_FUNCTIONS, 4'($urandom_range(2, 15)));
         end
         write_csr(mgbe_pkg::CSR_SUBTRACT_ORIGIN, 4'($urandom_range(0, 1)));
         quiet_phase = (phase == 3);
         // long receiver hold-off while beats keep coming
         if (phase == 1) hold_request = 1;
         for (int k = 0; k < 8; k++) begin
            op  = ((phase == 1 && k < 3) || $urandom_range(0, 9) >= 6) ? mgbe_pkg::OP_EVAL
                                                                       : mgbe_pkg::OP_LOAD;
            fi  = 3'($urandom());
            ci  = ($urandom_range(0, 7) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 262));
            pos = 16'($urandom());
            send_beat(op, fi, ci, random_coeff(), pos, 0);
            idle_sender(sender_gap());
         end
         // sender waits until every result of this phase is back
         if (phase == 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_values.size() != 0) @(posedge clock);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_values.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/mgbe_pkg.sv
design/multilevel_gaussian_basis_eval_core.sv
bench/testbench.sv
